### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/ficu_pkg.sv
// Package: operation codes and helpers for the float/integer conversion unit
package ficu_pkg;
	localparam int OpW = 4;
	localparam int DataW = 64;
	typedef enum logic [OpW-1:0] {
		OP_D2I = 4'd0, OP_D2L = 4'd1, OP_F2I = 4'd2, OP_F2L = 4'd3, OP_I2F = 4'd4,
		OP_I2D = 4'd5, OP_L2F = 4'd6, OP_L2D = 4'd7, OP_F2D = 4'd8, OP_D2F = 4'd9
	} op_t;
	localparam logic [63:0] INT_MAX_C = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] LONG_MAX_C = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] F_INF_C = 32'h7F80_0000;

	function automatic logic is_valid_op(input logic [OpW-1:0] op);
		is_valid_op = (op <= OP_D2F);
	endfunction
endpackage

### hw/rtl/ficu_pipe.sv
// Four-stage conversion datapath with stall-capable valid pipeline
`include "assert_macros.svh"
module ficu_pipe import ficu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OpW-1:0]   in_op,
	input  logic [DataW-1:0] in_x,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DataW-1:0] out_r
);
	typedef enum logic [1:0] {K_NONE, K_F2I, K_I2F, K_D2F} kind_t;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;

	// stage 1: unpack into a common form
	kind_t kind_s1;
	logic sign_s1, is32_s1, nan_s1, zero_s1, inf_s1, direct_s1;
	logic [63:0] direct_r_s1, mag_s1;
	logic signed [12:0] exp_s1;
	kind_t kind_c;
	logic sign_c, is32_c, nan_c, zero_c, inf_c, direct_c;
	logic [63:0] direct_r_c, mag_c, lo;
	logic signed [12:0] exp_c;
	logic [10:0] de;
	logic [51:0] df;
	logic [7:0] fe;
	logic [22:0] ff;
	logic [4:0] fp;

	always_comb begin
		lo = {32'd0, in_x[31:0]};
		de = in_x[62:52];
		df = in_x[51:0];
		fe = in_x[30:23];
		ff = in_x[22:0];
		fp = 5'd0;
		for (int i = 0; i < 23; i++)
			if (ff[i]) fp = 5'(i);
		kind_c = K_NONE;
		sign_c = 1'b0;
		is32_c = 1'b0;
		nan_c = 1'b0;
		zero_c = 1'b0;
		inf_c = 1'b0;
		direct_c = 1'b0;
		direct_r_c = '0;
		mag_c = '0;
		exp_c = '0;
		unique case (in_op)
			OP_D2I, OP_D2L: begin
				kind_c = K_F2I;
				is32_c = (in_op == OP_D2I);
				sign_c = in_x[63];
				nan_c = (de == 11'h7FF) && (df != 0);
				mag_c = {11'd0, de != 0, df};
				exp_c = 13'(de) - 13'sd1023;
			end
			OP_F2I, OP_F2L: begin
				kind_c = K_F2I;
				is32_c = (in_op == OP_F2I);
				sign_c = in_x[31];
				nan_c = (fe == 8'hFF) && (ff != 0);
				mag_c = {11'd0, fe != 0, ff, 29'd0};
				exp_c = (fe == 8'hFF) ? 13'sd1024 : 13'(fe) - 13'sd127;
			end
			OP_I2F, OP_I2D: begin
				kind_c = K_I2F;
				is32_c = (in_op == OP_I2F);
				sign_c = in_x[31];
				mag_c = in_x[31] ? (64'h1_0000_0000 - lo) : lo;
				exp_c = (in_op == OP_I2F) ? 13'sd127 : 13'sd1023;
			end
			OP_L2F, OP_L2D: begin
				kind_c = K_I2F;
				is32_c = (in_op == OP_L2F);
				sign_c = in_x[63];
				mag_c = in_x[63] ? (64'd0 - in_x) : in_x;
				exp_c = (in_op == OP_L2F) ? 13'sd127 : 13'sd1023;
			end
			OP_F2D: begin
				direct_c = 1'b1;
				if (fe == 8'hFF)
					direct_r_c = {in_x[31], 11'h7FF, ff != 0, ff[21:0], 29'd0};
				else if (fe == 0 && ff == 0)
					direct_r_c = {in_x[31], 63'd0};
				else if (fe == 0)
					direct_r_c = {in_x[31], 11'(11'd874 + 11'(fp)),
						52'({ff, 29'd0} << (5'd23 - fp))};
				else
					direct_r_c = {in_x[31], 11'(11'(fe) + 11'd896), ff, 29'd0};
			end
			OP_D2F: begin
				kind_c = K_D2F;
				sign_c = in_x[63];
				nan_c = (de == 11'h7FF) && (df != 0);
				inf_c = (de == 11'h7FF) && (df == 0);
				zero_c = (de == 0) && (df == 0);
				mag_c = {11'd0, de != 0, df};
				exp_c = (de == 0) ? 13'sd1 : 13'(de);
				direct_r_c = {32'd0, in_x[63], 8'hFF, df[51:29]};
			end
			default: begin
				direct_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= kind_c;
			sign_s1 <= sign_c;
			is32_s1 <= is32_c;
			nan_s1 <= nan_c;
			zero_s1 <= zero_c;
			inf_s1 <= inf_c;
			direct_s1 <= direct_c;
			direct_r_s1 <= direct_r_c;
			mag_s1 <= mag_c;
			exp_s1 <= exp_c;
		end
	end

	// stage 2: find leading one
	logic [5:0] lz_c;
	logic nz_c;
	always_comb begin
		lz_c = 6'd0;
		nz_c = (mag_s1 != 0);
		for (int i = 0; i < 64; i++)
			if (mag_s1[i]) lz_c = 6'(i);
	end

	kind_t kind_s2;
	logic sign_s2, is32_s2, nan_s2, zero_s2, inf_s2, direct_s2, nz_s2;
	logic [63:0] direct_r_s2, mag_s2;
	logic signed [12:0] exp_s2;
	logic [5:0] p_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2 <= kind_s1;
			sign_s2 <= sign_s1;
			is32_s2 <= is32_s1;
			nan_s2 <= nan_s1;
			zero_s2 <= zero_s1;
			inf_s2 <= inf_s1;
			direct_s2 <= direct_s1;
			direct_r_s2 <= direct_r_s1;
			mag_s2 <= mag_s1;
			exp_s2 <= exp_s1;
			p_s2 <= lz_c;
			nz_s2 <= nz_c;
		end
	end

	// stage 3: shift, keep guard and sticky
	logic [63:0] sh_c;
	logic [6:0] rs_c;
	logic [63:0] lostmask_c;
	logic halfb_c, stk_c, sat_c, under_c, tiny_c;
	logic signed [13:0] te_c;
	logic [5:0] mb;
	always_comb begin
		sh_c = '0;
		rs_c = '0;
		halfb_c = 1'b0;
		stk_c = 1'b0;
		sat_c = 1'b0;
		under_c = 1'b0;
		tiny_c = 1'b0;
		te_c = '0;
		lostmask_c = '0;
		mb = is32_s2 ? 6'd23 : 6'd52;
		unique case (kind_s2)
			K_F2I: begin
				sat_c = exp_s2 >= (is32_s2 ? 13'sd31 : 13'sd63);
				under_c = exp_s2 < 0;
				if (exp_s2 >= 13'sd52)
					sh_c = mag_s2 << 6'(exp_s2 - 13'sd52);
				else if (!under_c)
					sh_c = mag_s2 >> 6'(13'sd52 - exp_s2);
			end
			K_I2F: begin
				if (p_s2 <= mb) begin
					sh_c = mag_s2 << (mb - p_s2);
				end else begin
					rs_c = 7'(p_s2 - mb);
				end
			end
			K_D2F: begin
				te_c = 14'(exp_s2) - 14'sd896;
				sat_c = te_c >= 14'sd255;
				if (te_c >= 14'sd1) begin
					rs_c = 7'd29;
				end else begin
					tiny_c = 1'b1;
					rs_c = (14'sd926 - 14'(exp_s2) >= 14'sd64) ? 7'd64
						: 7'(14'sd926 - 14'(exp_s2));
				end
			end
			default: begin
			end
		endcase
		if (kind_s2 != K_F2I && rs_c != 0) begin
			if (rs_c >= 7'd64) begin
				sh_c = '0;
				halfb_c = 1'b0;
				stk_c = nz_s2;
			end else begin
				sh_c = mag_s2 >> rs_c[5:0];
				lostmask_c = (64'd1 << rs_c[5:0]) - 64'd1;
				halfb_c = mag_s2[rs_c[5:0] - 6'd1];
				stk_c = ((mag_s2 & (lostmask_c >> 1)) != 0);
			end
		end
	end

	kind_t kind_s3;
	logic sign_s3, is32_s3, nan_s3, zero_s3, inf_s3, direct_s3, nz_s3;
	logic halfb_s3, stk_s3, sat_s3, under_s3, tiny_s3;
	logic [63:0] direct_r_s3, sh_s3;
	logic [7:0] te_s3;
	logic [10:0] ie_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en3) begin
			kind_s3 <= kind_s2;
			sign_s3 <= sign_s2;
			is32_s3 <= is32_s2;
			nan_s3 <= nan_s2;
			zero_s3 <= zero_s2;
			inf_s3 <= inf_s2;
			direct_s3 <= direct_s2;
			direct_r_s3 <= direct_r_s2;
			nz_s3 <= nz_s2;
			halfb_s3 <= halfb_c;
			stk_s3 <= stk_c;
			sat_s3 <= sat_c;
			under_s3 <= under_c;
			tiny_s3 <= tiny_c;
			sh_s3 <= sh_c;
			te_s3 <= 8'(te_c - 14'sd1);
			ie_s3 <= 11'(13'(p_s2) + exp_s2 - 13'sd1);
		end
	end

	// stage 4: round, negate, pack
	logic [63:0] r_c, q_c, mag_t;
	logic inc_c;
	always_comb begin
		r_c = '0;
		inc_c = halfb_s3 && (stk_s3 || sh_s3[0]);
		q_c = sh_s3 + {63'd0, inc_c};
		mag_t = '0;
		if (direct_s3) begin
			r_c = direct_r_s3;
		end else begin
			unique case (kind_s3)
				K_F2I: begin
					if (nan_s3 || under_s3)
						r_c = '0;
					else if (sat_s3)
						r_c = is32_s3 ? (sign_s3 ? 64'h8000_0000 : INT_MAX_C)
							: (sign_s3 ? ~LONG_MAX_C : LONG_MAX_C);
					else begin
						mag_t = sign_s3 ? (64'd0 - sh_s3) : sh_s3;
						r_c = is32_s3 ? {32'd0, mag_t[31:0]} : mag_t;
					end
				end
				K_I2F: begin
					if (!nz_s3)
						r_c = '0;
					else if (is32_s3)
						r_c = {32'd0, sign_s3, 31'({ie_s3[7:0], 23'd0} + q_c[31:0])};
					else
						r_c = {sign_s3, 63'({ie_s3, 52'd0} + q_c)};
				end
				K_D2F: begin
					if (nan_s3)
						r_c = {32'd0, direct_r_s3[31], 9'h1FF, direct_r_s3[21:0]};
					else if (inf_s3 || sat_s3)
						r_c = {32'd0, sign_s3, F_INF_C[30:0]};
					else if (zero_s3)
						r_c = {32'd0, sign_s3, 31'd0};
					else begin
						mag_t = tiny_s3 ? q_c : ({33'd0, te_s3, 23'd0} + q_c);
						if (mag_t >= {32'd0, F_INF_C}) mag_t = {32'd0, F_INF_C};
						r_c = {32'd0, sign_s3, mag_t[30:0]};
					end
				end
				default: r_c = '0;
			endcase
		end
	end

	logic [63:0] r_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en4) begin
			r_s4 <= r_c;
		end
	end
	assign out_r = r_s4;

	`ASSERT_IMPL(a_hold, clk, arst_n, v_s4 && !out_ready |=> v_s4 && $stable(r_s4), "stalled word changed")
	`ASSERT_IMPL(a_adv, clk, arst_n, v_s3 && en4 |=> v_s4, "word dropped between stages")
	`ASSERT_NEVER(a_rdy, clk, arst_n, !in_ready && !v_s1, "stall with empty first stage")
endmodule

### hw/rtl/float_integer_conversion_unit_top.sv
// Top level of the float/integer conversion unit
// Converts between single, double, int and long per the opcode, one word per
// cycle while the output is not stalled, through a four-stage pipeline
// (unpack, leading-one search, align, round and pack); a stall holds each full stage whose next stage holds.
module float_integer_conversion_unit_top import ficu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata, // [3:0] operation, [67:4] operand_bits, [71:68] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata  // [63:0] result_bits
);
	ficu_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_op(s_axis_tdata[3:0]),
		.in_x(s_axis_tdata[67:4]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_r(m_axis_tdata)
	);
endmodule

### tb/float_integer_conversion_unit_checker.sv
// Checker for the float/integer conversion unit: predicts each conversion and compares results
module float_integer_conversion_unit_checker import ficu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] FRAC52 = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] FRAC23 = 64'h0000_0000_007F_FFFF;

	logic [63:0] expected_results[$];

	function automatic int lead_one(input logic [63:0] v);
		int p;
		p = -1;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = i;
		return p;
	endfunction

	function automatic logic [63:0] shift_round_even(input logic [63:0] v, input int s);
		logic [63:0] q, rem, half;
		if (s == 0) return v;
		if (s >= 64) return 64'd0;
		q = v >> s;
		rem = v & ((64'd1 << s) - 64'd1);
		half = 64'd1 << (s - 1);
		if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		return q;
	endfunction

	function automatic logic [63:0] widen_single(input logic [31:0] x);
		logic [63:0] sgn, f;
		logic [7:0] e;
		int p;
		sgn = {x[31], 63'd0};
		e = x[30:23];
		f = {41'd0, x[22:0]};
		if (e == 8'hFF) begin
			if (f != 0) return sgn | 64'h7FF8_0000_0000_0000 | (f << 29);
			return sgn | 64'h7FF0_0000_0000_0000;
		end
		if (e == 0) begin
			if (f == 0) return sgn;
			p = lead_one(f);
			return sgn | (64'(p + 874) << 52) | ((f << (52 - p)) & FRAC52);
		end
		return sgn | (64'(e + 896) << 52) | (f << 29);
	endfunction

	function automatic logic [63:0] narrow_double(input logic [63:0] d);
		logic [31:0] sgn;
		int e, te;
		logic [63:0] f, m, bits;
		sgn = {d[63], 31'd0};
		e = int'(d[62:52]);
		f = d & FRAC52;
		if (e == 2047) begin
			if (f != 0) return {32'd0, sgn | 32'h7FC0_0000 | 32'(f >> 29)};
			return {32'd0, sgn | F_INF_C};
		end
		if (e == 0) begin
			if (f == 0) return {32'd0, sgn};
			m = f;
			e = 1;
		end else begin
			m = f | (64'd1 << 52);
		end
		te = e - 896;
		if (te >= 255) return {32'd0, sgn | F_INF_C};
		if (te >= 1) bits = (64'(te - 1) << 23) + shift_round_even(m, 29);
		else bits = shift_round_even(m, 926 - e);
		if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
		return {32'd0, sgn | bits[31:0]};
	endfunction

	function automatic logic [63:0] truncate_to_int(input logic [63:0] d, input int n);
		logic [63:0] mask, m, mag, lim;
		int e, ue;
		mask = (n == 64) ? '1 : 64'hFFFF_FFFF;
		e = int'(d[62:52]);
		if (e == 2047 && (d & FRAC52) != 0) return 64'd0;
		ue = e - 1023;
		if (ue >= n - 1) begin
			lim = 64'd1 << (n - 1);
			return (d[63] ? lim : lim - 64'd1) & mask;
		end
		if (ue < 0) return 64'd0;
		m = (d & FRAC52) | (64'd1 << 52);
		mag = (ue >= 52) ? (m << (ue - 52)) : (m >> (52 - ue));
		return (d[63] ? -mag : mag) & mask;
	endfunction

	function automatic logic [63:0] round_int_to_float(input logic neg, input logic [63:0] mag,
			input int mbits, input int bias, input int width);
		int p;
		logic [63:0] sig;
		if (mag == 0) return 64'd0;
		p = lead_one(mag);
		if (p <= mbits) sig = mag << (mbits - p);
		else sig = shift_round_even(mag, p - mbits);
		return (64'(neg) << (width - 1)) + (64'(p + bias - 1) << mbits) + sig;
	endfunction

	function automatic logic [63:0] convert(input logic [3:0] op, input logic [63:0] x);
		logic [63:0] lo, m32, m64;
		lo = {32'd0, x[31:0]};
		m32 = x[31] ? (64'h1_0000_0000 - lo) : lo;
		m64 = x[63] ? -x : x;
		case (op)
			OP_D2I: return truncate_to_int(x, 32);
			OP_D2L: return truncate_to_int(x, 64);
			OP_F2I: return truncate_to_int(widen_single(x[31:0]), 32);
			OP_F2L: return truncate_to_int(widen_single(x[31:0]), 64);
			OP_I2F: return round_int_to_float(x[31], m32, 23, 127, 32);
			OP_I2D: return round_int_to_float(x[31], m32, 52, 1023, 64);
			OP_L2F: return round_int_to_float(x[63], m64, 23, 127, 32);
			OP_L2D: return round_int_to_float(x[63], m64, 52, 1023, 64);
			OP_F2D: return widen_single(x[31:0]);
			OP_D2F: return narrow_double(x);
			default: return 64'd0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
	end

	assign pending_count = expected_results.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(convert(s_axis_tdata[3:0], s_axis_tdata[67:4]));
			if (m_axis_tvalid && m_axis_tready) begin
				result_count++;
				if (expected_results.size() == 0)
					report_mismatch("unexpected word", m_axis_tdata, 64'd0);
				else if (m_axis_tdata !== expected_results[0])
					report_mismatch("result_bits", m_axis_tdata, expected_results.pop_front());
				else
					void'(expected_results.pop_front());
			end
		end
	end
endmodule

### tb/float_integer_conversion_unit_top_tb.sv
// Testbench top for the float/integer conversion unit: stimulus, idling and verdict
module float_integer_conversion_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ficu_pkg::*;

	localparam int RANDOM_WORDS = 1050;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	int          fail_count, pending_count, result_count;
	int          cycle_count;
	int          words_sent;
	bit          steady_phase;

	float_integer_conversion_unit_top uut (.*);

	float_integer_conversion_unit_checker checker_i (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("float_integer_conversion_unit_top verification failed");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= steady_phase ? 1'b1 : ($urandom_range(99) >= 35);

	function automatic logic [63:0] random_operand();
		logic [63:0] x;
		logic [10:0] e;
		x = {$urandom, $urandom};
		case ($urandom_range(7))
			0: x[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
			1: x[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
			2: begin
				e = 11'(1023 + $urandom_range(70) - 5);
				x[62:52] = e;
			end
			3: x[62:52] = 11'(896 + $urandom_range(40) - 30);
			4: x = x >> $urandom_range(63);
			5: x[30:23] = 8'(127 + $urandom_range(70) - 5);
			6: x = {{32{x[31]}}, x[31:0]} >> $urandom_range(40);
			default: ;
		endcase
		return x;
	endfunction

	task automatic send_word(input logic [3:0] op, input logic [63:0] x);
		while (!steady_phase && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, x, op};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		words_sent++;
	endtask

	initial begin
		logic [63:0] corner[$];
		cycle_count = 0;
		words_sent = 0;
		steady_phase = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		corner = '{64'd0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h0000_0000_7FC0_0001,
			64'h0000_0000_7F80_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h0000_0000_8000_0000, 64'h0000_0000_0000_0001, 64'h41E0_0000_0000_0000,
			64'h43E0_0000_0000_0000, 64'h0000_0000_0100_0001, 64'h0020_0000_1000_0000,
			64'h3690_0000_0000_0001, 64'h47EF_FFFF_F000_0000, 64'h0000_0000_00FF_FFFF,
			64'h0000_0000_0000_0000};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int op = 0; op < 16; op++)
			send_word(4'(op), corner[op % corner.size()]);
		foreach (corner[i])
			send_word(4'($urandom_range(9)), corner[i]);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady_phase = (i >= 400 && i < 550);
			send_word($urandom_range(99) < 3 ? 4'($urandom_range(15, 10))
				: 4'($urandom_range(9)), random_operand());
		end
		steady_phase = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("%0d words sent through all ten conversions, unused codes and edge operands",
			words_sent);
		$display("%0d results checked, %0d mismatches", result_count, fail_count);
		if (fail_count == 0)
			$display("float_integer_conversion_unit_top verification clean");
		else
			$display("float_integer_conversion_unit_top verification failed");
		$finish;
	end
endmodule
